// ===== rtl/mau_pkg.sv =====
`default_nettype none
package mau_pkg;
  localparam int unsigned WORD_BITS_DEF = 31;
  localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_t;
endpackage
`default_nettype wire

// ===== rtl/mau_if.sv =====
`default_nettype none
interface mau_in_if #(parameter int unsigned WORD_BITS = 31);
  logic                 valid;
  logic                 ready;
  logic [1:0]           func;
  logic [WORD_BITS-1:0] operand_a;
  logic [WORD_BITS-1:0] operand_b;
  modport source (output valid, func, operand_a, operand_b, input ready);
  modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface

interface mau_out_if #(parameter int unsigned WORD_BITS = 31);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] result;
  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface
`default_nettype wire

// ===== rtl/mau_mulmod.sv =====
`default_nettype none
// Bit-serial modular multiply: MSB-first double-and-add, one multiplier bit per cycle.
// Residues x, y must be below m.
module mau_mulmod
  import mau_pkg::*;
#(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [WORD_BITS-1:0] x,
  input  wire logic [WORD_BITS-1:0] y,
  input  wire logic [WORD_BITS-1:0] m,
  output logic                      done,
  output logic [WORD_BITS-1:0]      p
);
  localparam int unsigned CW = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] acc_r, acc_nxt, x_r, x_nxt, y_r, y_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt, done_r, done_nxt;
  logic [WORD_BITS:0]   dbl, dred, sum;
  logic [WORD_BITS-1:0] dmod;

  always_comb begin
    dbl  = {acc_r, 1'b0};
    dred = dbl - {1'b0, m};
    dmod = dred[WORD_BITS] ? acc_r << 1 : dred[WORD_BITS-1:0];
    sum  = {1'b0, dmod} + (y_r[WORD_BITS-1] ? {1'b0, x_r} : '0);
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      x_nxt    = x;
      y_nxt    = y;
      cnt_nxt  = CW'(WORD_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = (sum >= {1'b0, m}) ? WORD_BITS'(sum - {1'b0, m}) : sum[WORD_BITS-1:0];
      y_nxt   = y_r << 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
  end

  assign done = done_r;
  assign p    = acc_r;
endmodule
`default_nettype wire

// ===== rtl/modular_arithmetic_unit.sv =====
`default_nettype none
// Flow after accept: both operands are first reduced modulo the modulus, then add/sub
//   finishes in ST_ALU, multiply runs one modular multiply, and divide raises the divisor
//   to m-2 (one or two multiplies per exponent bit over WORD_BITS bits), then does a final
//   multiply by the reduced dividend.
// Throughput: one item in flight; the next is taken once the block is idle again.
//   A waiting result sits in the output register while the next item reduces.
// Reset: synchronous active-low rst_n clears control and loads modulus 1000000007.
module modular_arithmetic_unit
  import mau_pkg::*;
#(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [WORD_BITS-1:0] cfg_wdata,
  mau_in_if.sink                    in_ch,
  mau_out_if.source                 out_ch
);
  localparam int unsigned CW = $clog2(WORD_BITS + 1);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_RED  = 7'b0000010,
    ST_ALU  = 7'b0000100,
    ST_SQ   = 7'b0001000,   // acc <- acc*base in flight
    ST_AM   = 7'b0010000,   // exponent bit decides multiply or square only
    ST_FIN  = 7'b0100000,   // final product in flight
    ST_OUT  = 7'b1000000    // base <- base^2 in flight
  } state_t;

  state_t               state_r, state_nxt;
  logic [WORD_BITS-1:0] mod_r;
  logic [WORD_BITS-1:0] a_r, a_nxt, qa_r, qa_nxt, qb_r, qb_nxt;
  logic [WORD_BITS-1:0] ra_r, ra_nxt, rb_r, rb_nxt;
  logic [1:0]           func_r, func_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [WORD_BITS-1:0] acc_r, acc_nxt, base_r, base_nxt, exp_r, exp_nxt, res_r, res_nxt;
  logic                 ovalid_r, ovalid_nxt, mstart_r, mstart_nxt, pheld_r, pheld_nxt;
  logic                 out_free;
  logic [WORD_BITS-1:0] mx, my;
  logic                 mdone;
  logic [WORD_BITS-1:0] mp;
  logic [WORD_BITS:0]   ta, tb, sa, sb, addr;
  logic [WORD_BITS-1:0] mstep_x, mstep_y;

  mau_mulmod #(.WORD_BITS(WORD_BITS)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mstart_r), .x(mx), .y(my), .m(mod_r),
    .done(mdone), .p(mp)
  );

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign out_ch.valid  = ovalid_r;
  assign out_ch.result = res_r;
  // result register can take a new item this cycle
  assign out_free      = !ovalid_r || out_ch.ready;

  // restoring remainder step, one dividend bit per cycle, both operands at once
  always_comb begin
    ta = {ra_r, qa_r[WORD_BITS-1]};
    tb = {rb_r, qb_r[WORD_BITS-1]};
    sa = ta - {1'b0, mod_r};
    sb = tb - {1'b0, mod_r};
    addr = {1'b0, ra_r} + {1'b0, rb_r};
  end

  // squaring feeds base on both inputs, every other multiply takes acc and base
  always_comb begin
    mstep_x = (state_r == ST_OUT) ? base_r : acc_r;
    mstep_y = base_r;
    mx = mstep_x;
    my = mstep_y;
  end

  always_comb begin
    state_nxt  = state_r;
    func_nxt   = func_r;
    qa_nxt     = qa_r;
    qb_nxt     = qb_r;
    ra_nxt     = ra_r;
    rb_nxt     = rb_r;
    a_nxt      = a_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    base_nxt   = base_r;
    exp_nxt    = exp_r;
    res_nxt    = res_r;
    mstart_nxt = 1'b0;
    pheld_nxt  = pheld_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          func_nxt  = in_ch.func;
          qa_nxt    = in_ch.operand_a;
          qb_nxt    = in_ch.operand_b;
          ra_nxt    = '0;
          rb_nxt    = '0;
          cnt_nxt   = CW'(WORD_BITS);
          state_nxt = ST_RED;
        end
      end
      ST_RED: begin
        ra_nxt  = sa[WORD_BITS] ? ta[WORD_BITS-1:0] : sa[WORD_BITS-1:0];
        rb_nxt  = sb[WORD_BITS] ? tb[WORD_BITS-1:0] : sb[WORD_BITS-1:0];
        qa_nxt  = qa_r << 1;
        qb_nxt  = qb_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) state_nxt = ST_ALU;
      end
      ST_ALU: begin
        // results computed here wait in this state until the output register is free
        a_nxt = ra_r;
        if (mod_r < WORD_BITS'(2)) begin
          if (out_free) begin
            res_nxt = '0; ovalid_nxt = 1'b1; state_nxt = ST_IDLE;
          end
        end else begin
          case (func_r)
            FUNC_ADD: begin
              if (out_free) begin
                res_nxt = (addr >= {1'b0, mod_r}) ? WORD_BITS'(addr - {1'b0, mod_r})
                                                  : addr[WORD_BITS-1:0];
                ovalid_nxt = 1'b1; state_nxt = ST_IDLE;
              end
            end
            FUNC_SUB: begin
              if (out_free) begin
                res_nxt = (ra_r >= rb_r) ? ra_r - rb_r : ra_r + mod_r - rb_r;
                ovalid_nxt = 1'b1; state_nxt = ST_IDLE;
              end
            end
            FUNC_MUL: begin
              acc_nxt = ra_r; base_nxt = rb_r; mstart_nxt = 1'b1; state_nxt = ST_FIN;
            end
            default: begin
              if (rb_r == '0) begin
                // zero divisor
                if (out_free) begin
                  res_nxt = '0; ovalid_nxt = 1'b1; state_nxt = ST_IDLE;
                end
              end else begin
                // inverse as b^(m-2), exponent walked LSB first
                acc_nxt   = WORD_BITS'(1);
                base_nxt  = rb_r;
                exp_nxt   = mod_r - WORD_BITS'(2);
                cnt_nxt   = CW'(WORD_BITS);
                state_nxt = ST_AM;
              end
            end
          endcase
        end
      end
      ST_AM: begin
        mstart_nxt = 1'b1;
        state_nxt  = exp_r[0] ? ST_SQ : ST_OUT;
      end
      ST_SQ: begin
        if (mdone) begin
          acc_nxt    = mp;
          mstart_nxt = 1'b1;
          state_nxt  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (mdone) begin
          exp_nxt = exp_r >> 1;
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == CW'(1)) begin
            // dividend times inverse
            acc_nxt = a_r; base_nxt = acc_r; mstart_nxt = 1'b1; state_nxt = ST_FIN;
          end else begin
            base_nxt  = mp;
            state_nxt = ST_AM;
          end
        end
      end
      ST_FIN: begin
        // product stays on mp after done, so it can wait for the output register
        if (mdone || pheld_r) begin
          if (out_free) begin
            res_nxt = mp; ovalid_nxt = 1'b1; pheld_nxt = 1'b0; state_nxt = ST_IDLE;
          end else begin
            pheld_nxt = 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      mod_r    <= MODULUS_RESET[WORD_BITS-1:0];
      ovalid_r <= 1'b0;
      mstart_r <= 1'b0;
      pheld_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      if (cfg_we) mod_r <= cfg_wdata;
      ovalid_r <= ovalid_nxt;
      mstart_r <= mstart_nxt;
      pheld_r  <= pheld_nxt;
    end
    func_r <= func_nxt;
    qa_r   <= qa_nxt;
    qb_r   <= qb_nxt;
    ra_r   <= ra_nxt;
    rb_r   <= rb_nxt;
    a_r    <= a_nxt;
    cnt_r  <= cnt_nxt;
    acc_r  <= acc_nxt;
    base_r <= base_nxt;
    exp_r  <= exp_nxt;
    res_r  <= res_nxt;
  end

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == ST_IDLE) else $error("ready outside idle");
  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && mod_r >= WORD_BITS'(2)) |-> out_ch.result < mod_r)
    else $error("result not reduced");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.result)))
    else $error("result dropped while stalled");
`endif
endmodule
`default_nettype wire

// ===== tb/modular_arithmetic_unit_test.sv =====
`default_nettype none
module modular_arithmetic_unit_test
  import mau_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WB = 31;
  localparam logic [WB-1:0] WMAX = {WB{1'b1}};
  // bound for the worst divide, with slack
  localparam int unsigned DIV_CYCLES = 2400;
  localparam int unsigned LONG_HOLD = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [WB-1:0] cfg_wdata = '0;

  mau_in_if #(.WORD_BITS(WB)) in_ch ();
  mau_out_if #(.WORD_BITS(WB)) out_ch ();

  modular_arithmetic_unit #(.WORD_BITS(WB)) u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: the modulus as the block should hold it.
  logic [WB-1:0] cur_modulus;
  logic [WB-1:0] expected_results[$];
  int unsigned mismatch_count = 0;

  // Receiver control
  bit out_stall_en = 1'b1;
  int unsigned hold_cycles = 0;
  int unsigned long_hold_reqs = 0;
  int unsigned long_hold_seen = 0;

  function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    return (x * y) % m;
  endfunction

  function automatic logic [WB-1:0] modular_result(func_t op, logic [WB-1:0] a_in,
                                                   logic [WB-1:0] b_in, logic [WB-1:0] m_in);
    logic [63:0] m, a, b, r, e, acc, base;
    m = 64'(m_in);
    if (m < 2) return '0;
    a = 64'(a_in) % m;
    b = 64'(b_in) % m;
    case (op)
      FUNC_ADD: r = (a + b) % m;
      FUNC_SUB: r = (a >= b) ? a - b : a + m - b;
      FUNC_MUL: r = mulmod(a, b, m);
      default: begin
        if (b == 0) begin
          r = 0;
        end else begin
          // Fermat inverse b^(m-2), exponent walked over WB bits
          e = m - 2;
          acc = 1;
          base = b;
          for (int i = 0; i < WB; i++) begin
            if (e[0]) acc = mulmod(acc, base, m);
            base = mulmod(base, base, m);
            e = e >> 1;
          end
          r = mulmod(a, acc, m);
        end
      end
    endcase
    return r[WB-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [WB-1:0] got, logic [WB-1:0] want);
    mismatch_count++;
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  // Sender: one item, with an optional random idle burst first.
  // valid stays up after an accept unless an idle burst or a drain follows.
  bit in_idle_en = 1'b1;
  task automatic send_item(func_t op, logic [WB-1:0] a, logic [WB-1:0] b);
    if (in_idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= op;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    expected_results = {expected_results, modular_result(op, a, b, cur_modulus)};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    int unsigned guard;
    in_ch.valid <= 1'b0;
    guard = 0;
    while (expected_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DIV_CYCLES / 16) @(posedge clk);
  endtask

  task automatic write_modulus(logic [WB-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_modulus = value;
  endtask

  // Result checker: outputs sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_ch.result, '0);
      end else begin
        if (out_ch.result !== expected_results[0])
          report_mismatch("result", out_ch.result, expected_results[0]);
        void'(expected_results.pop_front());
      end
    end
  end

  // Receiver ready: random stall bursts, or a long counted hold on request.
  always @(posedge clk) begin
    if (long_hold_seen != long_hold_reqs) begin
      long_hold_seen <= long_hold_reqs;
      out_ch.ready <= 1'b0;
      hold_cycles <= LONG_HOLD - 1;
    end else if (hold_cycles != 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (out_stall_en && $urandom_range(0, 7) == 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= $urandom_range(0, 15);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic logic [WB-1:0] rand_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return WMAX;
      2: return WB'($urandom_range(0, 20));
      default: return WB'($urandom());
    endcase
  endfunction

  // Directed: field extremes, each op, zero divisor, near-modulus operands.
  task automatic test_directed();
    for (int op = 0; op < 4; op++) begin
      send_item(func_t'(op), '0, '0);
      send_item(func_t'(op), WMAX, WMAX);
      send_item(func_t'(op), WMAX, 31'd1);
      send_item(func_t'(op), cur_modulus - 1, cur_modulus);
    end
    send_item(FUNC_DIV, 31'd5, cur_modulus);      // divisor reduces to zero
    send_item(FUNC_SUB, 31'd1, cur_modulus - 1);  // negative difference wraps
    send_item(FUNC_DIV, 31'd7, 31'd3);
  endtask

  task automatic test_random(int unsigned n);
    func_t op;
    for (int unsigned i = 0; i < n; i++) begin
      op = func_t'($urandom_range(0, 3));
      send_item(op, rand_word(), rand_word());
    end
  endtask

  // Block fills while the receiver holds off; sender keeps offering.
  task automatic test_backpressure();
    long_hold_reqs++;
    in_idle_en = 1'b0;
    for (int i = 0; i < 8; i++) send_item(FUNC_ADD, rand_word(), rand_word());
    in_idle_en = 1'b1;
  endtask

  // Degenerate and small moduli, including the extremes.
  task automatic test_modulus_sweep();
    logic [WB-1:0] moduli[6] = '{31'd2, 31'd0, 31'd1, 31'd13, 31'd65537, WMAX};
    foreach (moduli[k]) begin
      write_modulus(moduli[k]);
      for (int op = 0; op < 4; op++) begin
        send_item(func_t'(op), WMAX, WMAX);
        send_item(func_t'(op), 31'd1, 31'd0);
      end
      test_random(60);
    end
    write_modulus(31'd9);  // composite
    test_random(40);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_ADD;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    out_ch.ready = 1'b0;
    cur_modulus = MODULUS_RESET[WB-1:0];
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random(500);
    test_modulus_sweep();
    write_modulus(31'd1000003);
    test_random(300);
    // last part: no idling on either side
    in_idle_en = 1'b0;
    out_stall_en = 1'b0;
    test_random(150);
    drain();

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Roughly 1400 items; even all divides with the longest stalls need well under 30 ms.
  initial begin
    #250ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire

// ===== tb/mau_tb_if.sv =====
`default_nettype none
// Channel interfaces come from the block's own interface file (mau_if.sv).
`default_nettype wire

// ===== modular_arithmetic_unit.f =====
rtl/mau_pkg.sv
rtl/mau_if.sv
rtl/mau_mulmod.sv
rtl/modular_arithmetic_unit.sv
tb/modular_arithmetic_unit_test.sv
tb/mau_tb_if.sv
